// ----- rtl/mse_pkg.sv -----
// ----------------------------------------------------------------------------
// mse_pkg
// sizes and derived widths shared by the merge sort engine and its channels
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int DATA_WIDTH = 32;

  // index into one buffer
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  // count that can hold MAX_ITEMS itself
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  // run bounds before clipping, up to twice the capacity
  localparam int POS_W  = CNT_W + 1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [POS_W-1:0]             pos_t;
  typedef logic [ADDR_W:0]              maddr_t;

endpackage

// ----- rtl/mse_if.sv -----
// ----------------------------------------------------------------------------
// mse_if
// valid/ready channels for the merge sort engine: loaded items and results
// ----------------------------------------------------------------------------
interface mse_in_if import mse_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mse_out_if import mse_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  final_res;

  modport source (output valid, output sorted_value, output final_res, input ready);
  modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

// ----- rtl/merge_sort_engine_unit.sv -----
// ----------------------------------------------------------------------------
// merge_sort_engine_unit
// collects a set of signed values and emits them in ascending order
// ----------------------------------------------------------------------------
// Loading takes one cycle per request; the request flagged last closes the
// set (at most MAX_ITEMS values, later ones are dropped) and starts a bottom-up
// merge sort between two halves of one buffer memory with one read and one
// write port, in ceil(log2 N) passes for N values. Run heads are fetched
// through the single registered read port, in S_INIT_L/R/W per run pair and
// in S_FETCH/S_LATCH per merged value. Emission steps each value through
// S_EMIT_RD, S_EMIT_LD and S_EMIT_OUT, waiting on results.ready. No new set is
// taken until the last sorted value is delivered. No clearing pass after reset.
module merge_sort_engine_unit import mse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mse_in_if.sink     items,
  mse_out_if.source  results
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT_L,
    S_INIT_R,
    S_INIT_W,
    S_MERGE,
    S_FETCH,
    S_LATCH,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_OUT
  } state_t;

  state_t state;

  data_t  mem [2*MAX_ITEMS];
  data_t  rd_data;
  maddr_t rd_addr;
  maddr_t wr_addr;
  data_t  wr_data;
  logic   wr_en;

  cnt_t   count;
  cnt_t   n;
  pos_t   lo;
  pos_t   w;
  cnt_t   j;
  cnt_t   k;
  cnt_t   o;
  cnt_t   mid;
  cnt_t   hi;
  logic   src;
  logic   side;
  data_t  head_l;
  data_t  head_r;

  logic   out_valid;
  data_t  out_value;
  logic   out_final;

  logic   room;
  cnt_t   count_next;
  pos_t   lo_next;
  pos_t   w_next;
  pos_t   mid_raw;
  pos_t   hi_raw;
  logic   l_ok;
  logic   r_ok;
  logic   take_left;
  cnt_t   o_next;

  // buffer memory, bank bit selects the half
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    room       = (count < cnt_t'(MAX_ITEMS));
    count_next = count + cnt_t'(room);
    lo_next    = lo + (w << 1);
    w_next     = w << 1;
    mid_raw    = lo + w;
    hi_raw     = lo + (w << 1);
    l_ok       = (j < mid);
    r_ok       = (k < hi);
    take_left  = l_ok && (!r_ok || (head_l < head_r));
    o_next     = o + cnt_t'(1);

    case (state)
      S_INIT_L:  rd_addr = {src, lo[ADDR_W-1:0]};
      S_INIT_R:  rd_addr = {src, k[ADDR_W-1:0]};
      S_FETCH:   rd_addr = side ? {src, k[ADDR_W-1:0]} : {src, j[ADDR_W-1:0]};
      S_EMIT_RD: rd_addr = {src, o[ADDR_W-1:0]};
      default:   rd_addr = {src, o[ADDR_W-1:0]};
    endcase

    wr_en   = 1'b0;
    wr_addr = {1'b0, count[ADDR_W-1:0]};
    wr_data = items.value;
    case (state)
      S_LOAD: begin
        wr_en = items.valid && room;
      end
      S_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = {~src, o[ADDR_W-1:0]};
        wr_data = take_left ? head_l : head_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign items.ready          = (state == S_LOAD);
  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.final_res    = out_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      out_valid <= 1'b0;
      src       <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (items.valid) begin
            count <= count_next;
            if (items.last) begin
              n   <= count_next;
              src <= 1'b0;
              lo  <= '0;
              w   <= pos_t'(1);
              o   <= '0;
              state <= (count_next == cnt_t'(1)) ? S_EMIT_RD : S_INIT_L;
            end
          end
        end
        S_INIT_L: begin
          j     <= lo[CNT_W-1:0];
          o     <= lo[CNT_W-1:0];
          mid   <= (mid_raw < pos_t'(n)) ? mid_raw[CNT_W-1:0] : n;
          k     <= (mid_raw < pos_t'(n)) ? mid_raw[CNT_W-1:0] : n;
          hi    <= (hi_raw < pos_t'(n)) ? hi_raw[CNT_W-1:0] : n;
          state <= S_INIT_R;
        end
        S_INIT_R: begin
          head_l <= rd_data;
          state  <= S_INIT_W;
        end
        S_INIT_W: begin
          head_r <= rd_data;
          state  <= S_MERGE;
        end
        S_MERGE: begin
          if (take_left) begin
            j <= j + cnt_t'(1);
          end else begin
            k <= k + cnt_t'(1);
          end
          side <= !take_left;
          if (o_next == hi) begin
            if (lo_next >= pos_t'(n)) begin
              lo  <= '0;
              w   <= w_next;
              src <= ~src;
              o   <= '0;
              state <= (w_next >= pos_t'(n)) ? S_EMIT_RD : S_INIT_L;
            end else begin
              lo    <= lo_next;
              state <= S_INIT_L;
            end
          end else begin
            o     <= o_next;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_LATCH;
        end
        S_LATCH: begin
          if (side) begin
            head_r <= rd_data;
          end else begin
            head_l <= rd_data;
          end
          state <= S_MERGE;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_valid <= 1'b1;
          out_value <= rd_data;
          out_final <= (o_next == n);
          o         <= o_next;
          state     <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            if (out_final) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no loading while a result is shown
  a_load_or_emit: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> !results.valid)
    else $error("load and emit overlap");

  // the set never grows past the buffer
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(MAX_ITEMS))
    else $error("item count past capacity");

  // merge pointers stay inside their runs
  a_merge_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_MERGE |-> (o < hi) && (j <= mid) && (k <= hi) && (mid <= hi))
    else $error("merge pointer out of run");

  // delivering the final result reopens loading
  a_final_reopens: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && results.final_res |=> items.ready && count == '0)
    else $error("final result did not reopen loading");
`endif

endmodule
